@@ rtl/dpks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpks_pkg
// Types and codes shared by the dot-product top-k search block.
// ----------------------------------------------------------------------------
package dpks_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRONG_LEN = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NO_VEC    = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] element_value;
    logic               element_last;
    logic [7:0]         vector_index;
    logic [6:0]         element_index;
    logic [4:0]         top_k;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [7:0]         index;
    logic signed [39:0] similarity;
    logic signed [15:0] read_value;
    logic [8:0]         vector_count;
    logic               result_last;
  } rsp_t;

  // one scored vector offered to the best list
  typedef struct packed {
    logic               vld;
    logic [15:0]        idx;
    logic signed [39:0] sim;
  } ins_t;

  localparam logic signed [39:0] SIM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SIM_MIN = 40'sh80_0000_0000;

endpackage

@@ rtl/dpks_best.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpks_best
// Sorted list of the best hits, highest similarity first, one insert a cycle.
// ----------------------------------------------------------------------------
module dpks_best #(
  parameter int K_MAX = 16,
  parameter int KW    = 5,
  parameter int KI_W  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  dpks_pkg::ins_t      ins,
  input  logic [KW-1:0]       k,
  input  logic [KI_W-1:0]     rd_ptr,
  output logic [15:0]         rd_idx,
  output logic signed [39:0]  rd_sim,
  output logic [KW-1:0]       fill
);

  logic [15:0]        best_idx [K_MAX];
  logic signed [39:0] best_sim [K_MAX];
  logic [K_MAX-1:0]   cond;

  // entries are sorted, so cond is monotonic and its first set bit is the slot
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      cond[j] = (32'(fill) <= j) || (ins.sim > best_sim[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ins.vld) begin
      for (int j = 0; j < K_MAX; j++) begin
        if (cond[j] && (j == 0 || !cond[(j > 0) ? j - 1 : 0])) begin
          best_idx[j] <= ins.idx;
          best_sim[j] <= ins.sim;
        end else if (j > 0 && cond[(j > 0) ? j - 1 : 0]) begin
          best_idx[j] <= best_idx[(j > 0) ? j - 1 : 0];
          best_sim[j] <= best_sim[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (ins.vld && fill < k) begin
      fill <= fill + KW'(1);
    end
  end

  assign rd_idx = best_idx[rd_ptr];
  assign rd_sim = best_sim[rd_ptr];

endmodule

@@ rtl/dot_product_top_k_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_top_k_search
// Vector store with brute-force dot-product top-k search.
// ----------------------------------------------------------------------------
// Request channel: req_valid / req_stall carry one req item per transfer.
// Each append or query element is written as it is accepted. A read answers
// through the memory output register and then the response register. A
// search runs one multiply-accumulate per cycle, stored element after
// stored element through the single read port of the vector memory, for
// opcode 2 after copying a named stored vector into the query buffer. The
// pipeline then drains; hits leave one per cycle unless rsp_stall is high.
// Response channel: rsp_valid / rsp_stall, one rsp item per transfer, from
// an output register; a stalled response holds, and the block takes the
// next request once that register is emptied or is being emptied.
// Configuration: cfg_we writes cfg_wdata into vector_length; write only
// while the block is idle.
// Reset (rst, synchronous) empties the store and clears the fill state and
// sets vector_length to 128; memory contents are left as they are.
// ----------------------------------------------------------------------------
module dot_product_top_k_search #(
  parameter int N_MAX   = 256,
  parameter int DIM_MAX = 128,
  parameter int K_MAX   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dpks_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dpks_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  localparam int VEC_W  = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int ELEM_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int CNT_W  = $clog2(N_MAX + 1);
  localparam int LEN_W  = $clog2(DIM_MAX + 1);
  localparam int KW     = $clog2(K_MAX + 1);
  localparam int KI_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int ACC_RAW = 32 + $clog2(DIM_MAX + 1);
  localparam int ACC_W  = (ACC_RAW > 41) ? ACC_RAW : 41;
  localparam int ADDR_W = VEC_W + ELEM_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COPY   = 7'b0000010,
    S_CWAIT  = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_READ   = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0]       vector_length;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] fp;
  logic             ferr;
  logic [KW-1:0]    kq;

  logic [VEC_W-1:0] cvi;
  logic [LEN_W-1:0] cj;
  logic             cp_v;
  logic [LEN_W-1:0] cp_j;

  logic [CNT_W-1:0] si;
  logic [LEN_W-1:0] sj;
  logic [KI_W-1:0]  ptr;

  // vector store and query buffer; the upper half of the query buffer holds
  // a copied stored vector so the streamed query stays intact
  logic signed [15:0] mem  [2**ADDR_W];
  logic signed [15:0] qbuf [2**(ELEM_W+1)];
  logic signed [15:0] m_q, q_q;
  logic               mem_we, q_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ELEM_W:0]    q_waddr, q_raddr;
  logic signed [15:0] q_wdata;
  logic               q_sel;

  // search pipeline
  logic                    p1_v, p1_first, p1_last;
  logic [CNT_W-1:0]        p1_idx;
  logic                    p2_v, p2_first, p2_last;
  logic [CNT_W-1:0]        p2_idx;
  logic signed [31:0]      prod;
  logic                    p3_v;
  logic [CNT_W-1:0]        p3_idx;
  logic signed [ACC_W-1:0] acc;
  logic                    p4_v;
  logic [CNT_W-1:0]        p4_idx;
  logic signed [39:0]      p4_sim;

  dpks_pkg::ins_t     ins;
  logic               best_clear;
  logic [15:0]        rd_idx;
  logic signed [39:0] rd_sim;
  logic [KW-1:0]      fill;

  logic               rsp_v;
  dpks_pkg::rsp_t     rsp_q;
  logic               out_free;
  dpks_pkg::rsp_t     read_rsp, hit_rsp;

  logic [LEN_W-1:0]   len;
  logic               acc_in, is_elem, wr_ok, ferr_new, vec_ok;
  logic [LEN_W-1:0]   fp_new;
  logic [KW-1:0]      k_sat;
  logic               res_v;
  dpks_pkg::rsp_t     res;
  state_t             state_next;
  logic               start_search, start_copy;
  logic               cnt_inc;

  function automatic dpks_pkg::rsp_t mk(dpks_pkg::kind_t kind, dpks_pkg::status_t st,
                                        logic [7:0] idx, logic [8:0] cnt);
    dpks_pkg::rsp_t r;
    r.kind         = kind;
    r.status       = st;
    r.index        = idx;
    r.similarity   = '0;
    r.read_value   = '0;
    r.vector_count = cnt;
    r.result_last  = 1'b1;
    return r;
  endfunction

  always_comb begin
    if (vector_length == 8'd0) begin
      len = LEN_W'(1);
    end else if (32'(vector_length) > DIM_MAX) begin
      len = LEN_W'(DIM_MAX);
    end else begin
      len = LEN_W'(vector_length);
    end
    k_sat = (32'(req.top_k) > K_MAX) ? KW'(K_MAX) : KW'(req.top_k);
  end

  assign out_free  = !rsp_v || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign acc_in    = req_valid && !req_stall;
  assign is_elem   = (req.opcode == dpks_pkg::OP_APPEND) || (req.opcode == dpks_pkg::OP_QUERY);
  assign wr_ok     = fp < len;
  assign fp_new    = wr_ok ? fp + LEN_W'(1) : fp;
  assign ferr_new  = ferr || !wr_ok;
  assign vec_ok    = !ferr_new && (fp_new == len);

  // decode an accepted request: immediate result, start of a longer job, or nothing more
  always_comb begin
    res_v        = 1'b0;
    res          = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_OK, 8'd0, 9'(count));
    state_next   = S_IDLE;
    start_search = 1'b0;
    start_copy   = 1'b0;
    cnt_inc      = 1'b0;
    if (acc_in) begin
      if (is_elem) begin
        if (req.element_last) begin
          if (!vec_ok) begin
            res_v = 1'b1;
            res   = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_WRONG_LEN, 8'd0, 9'(count));
          end else if (req.opcode == dpks_pkg::OP_APPEND) begin
            res_v = 1'b1;
            if (32'(count) >= N_MAX) begin
              res = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_FULL, 8'd0, 9'(count));
            end else begin
              cnt_inc = 1'b1;
              res = mk(dpks_pkg::KIND_APPEND, dpks_pkg::ST_OK, 8'(count),
                       9'(count + CNT_W'(1)));
            end
          end else if (count == '0) begin
            res_v = 1'b1;
            res   = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_NO_VEC, 8'd0, 9'(count));
          end else if (k_sat != '0) begin
            start_search = 1'b1;
            state_next   = S_SEARCH;
          end
        end
      end else if (count == '0) begin
        res_v = 1'b1;
        res   = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_NO_VEC, 8'd0, 9'(count));
      end else if (32'(req.vector_index) >= 32'(count)) begin
        res_v = 1'b1;
        res   = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_BAD_INDEX, 8'd0, 9'(count));
      end else if (req.opcode == dpks_pkg::OP_SEARCH) begin
        if (k_sat != '0) begin
          start_copy = 1'b1;
          state_next = S_COPY;
        end
      end else if (32'(req.element_index) >= 32'(len)) begin
        res_v = 1'b1;
        res   = mk(dpks_pkg::KIND_ERROR, dpks_pkg::ST_BAD_INDEX, 8'd0, 9'(count));
      end else begin
        state_next = S_READ;
      end
    end
  end

  // memory ports
  always_comb begin
    mem_we    = acc_in && req.opcode == dpks_pkg::OP_APPEND && wr_ok && 32'(count) < N_MAX;
    mem_waddr = {VEC_W'(count), ELEM_W'(fp)};
    q_we      = cp_v || (acc_in && req.opcode == dpks_pkg::OP_QUERY && wr_ok);
    q_waddr   = cp_v ? {1'b1, ELEM_W'(cp_j)} : {1'b0, ELEM_W'(fp)};
    q_wdata   = cp_v ? m_q : req.element_value;
    q_raddr   = {q_sel, ELEM_W'(sj)};
    if (state == S_COPY) begin
      mem_raddr = {cvi, ELEM_W'(cj)};
    end else if (state == S_SEARCH) begin
      mem_raddr = {VEC_W'(si), ELEM_W'(sj)};
    end else begin
      mem_raddr = {VEC_W'(req.vector_index), ELEM_W'(req.element_index)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= req.element_value;
    end
    m_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qbuf[q_waddr] <= q_wdata;
    end
    q_q <= qbuf[q_raddr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vector_length <= 8'd128;
      count         <= '0;
      fp            <= '0;
      ferr          <= 1'b0;
      cp_v          <= 1'b0;
      p1_v          <= 1'b0;
      q_sel         <= 1'b0;
    end else begin
      if (cfg_we) begin
        vector_length <= cfg_wdata;
      end
      cp_v <= (state == S_COPY);
      p1_v <= (state == S_SEARCH);
      unique case (state)
        S_IDLE: begin
          state <= state_next;
          if (acc_in) begin
            kq    <= k_sat;
            cvi   <= VEC_W'(req.vector_index);
            cj    <= '0;
            si    <= '0;
            sj    <= '0;
            q_sel <= start_copy;
            if (is_elem) begin
              fp   <= req.element_last ? '0 : fp_new;
              ferr <= req.element_last ? 1'b0 : ferr_new;
            end
            if (cnt_inc) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_COPY: begin
          cp_j <= cj;
          cj   <= cj + LEN_W'(1);
          if (cj == len - LEN_W'(1)) begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (sj == len - LEN_W'(1)) begin
            sj <= '0;
            if (si == count - CNT_W'(1)) begin
              state <= S_DRAIN;
            end else begin
              si <= si + CNT_W'(1);
            end
          end else begin
            sj <= sj + LEN_W'(1);
          end
        end
        S_DRAIN: begin
          ptr <= '0;
          if (!(p1_v || p2_v || p3_v || p4_v)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ptr <= ptr + KI_W'(1);
            if (KW'(ptr) + KW'(1) == fill) begin
              state <= S_IDLE;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign best_clear = start_search || start_copy;

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    p1_first <= (sj == '0);
    p1_last  <= (sj == len - LEN_W'(1));
    p1_idx   <= si;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_idx   <= p1_idx;
    prod     <= q_q * m_q;
    if (p2_v) begin
      acc <= (p2_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
    p3_idx <= p2_idx;
    p4_idx <= p3_idx;
    if (acc > ACC_W'(dpks_pkg::SIM_MAX)) begin
      p4_sim <= dpks_pkg::SIM_MAX;
    end else if (acc < ACC_W'(dpks_pkg::SIM_MIN)) begin
      p4_sim <= dpks_pkg::SIM_MIN;
    end else begin
      p4_sim <= 40'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
      p3_v <= p2_v && p2_last;
      p4_v <= p3_v;
    end
  end

  assign ins.vld = p4_v;
  assign ins.idx = 16'(p4_idx);
  assign ins.sim = p4_sim;

  dpks_best #(
    .K_MAX (K_MAX),
    .KW    (KW),
    .KI_W  (KI_W)
  ) u_best (
    .clk    (clk),
    .rst    (rst),
    .clear  (best_clear),
    .ins    (ins),
    .k      (kq),
    .rd_ptr (ptr),
    .rd_idx (rd_idx),
    .rd_sim (rd_sim),
    .fill   (fill)
  );

  always_comb begin
    read_rsp             = mk(dpks_pkg::KIND_READ, dpks_pkg::ST_OK, 8'd0, 9'(count));
    read_rsp.read_value  = m_q;
    hit_rsp              = mk(dpks_pkg::KIND_HIT, dpks_pkg::ST_OK, 8'(rd_idx), 9'(count));
    hit_rsp.similarity   = rd_sim;
    hit_rsp.result_last  = (KW'(ptr) + KW'(1) == fill);
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else if (res_v) begin
      rsp_v <= 1'b1;
      rsp_q <= res;
    end else if (state == S_READ) begin
      rsp_v <= 1'b1;
      rsp_q <= read_rsp;
    end else if (state == S_EMIT && out_free) begin
      rsp_v <= 1'b1;
      rsp_q <= hit_rsp;
    end else if (!rsp_stall) begin
      rsp_v <= 1'b0;
    end
  end

  assign rsp_valid = rsp_v;
  assign rsp       = rsp_q;

endmodule
